// ===== design/tts_pkg.sv =====
// Package: types, codes and constants of the thread table scheduler.
package tts_pkg;
    localparam int THREAD_COUNT_DEF = 16;

    localparam logic [1:0] OP_SCHEDULE = 2'd0;
    localparam logic [1:0] OP_SLEEP    = 2'd1;
    localparam logic [1:0] OP_KILL     = 2'd2;
    localparam logic [1:0] OP_CREATE   = 2'd3;

    localparam logic [1:0] ST_TERMINATED = 2'd0;
    localparam logic [1:0] ST_RUNNABLE   = 2'd1;
    localparam logic [1:0] ST_RUNNING    = 2'd2;
    localparam logic [1:0] ST_PAUSED     = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] now_time;
        logic [63:0] sleep_duration;
        logic [31:0] stack_pointer;
    } t_req;

    typedef struct packed {
        logic [3:0]  running_index;
        logic [31:0] next_stack_pointer;
        logic        status;
        logic [3:0]  new_index;
    } t_rsp;

    // Command broadcast from the sequencer to every cell.
    typedef struct packed {
        logic        wake;      // wake paused cells with wake time below now
        logic        sel_cur;   // act on the current cell
        logic        set_sp;    // write sp into selected cell
        logic        set_state; // write state into selected cell
        logic [1:0]  state_val;
        logic        set_wake;  // write wake time into selected cell
        logic        demote;    // running selected cell becomes runnable
    } t_cmd;
endpackage

// ===== design/tts_cell.sv =====
// One thread table entry: state, wake time and saved stack pointer.
module tts_cell #(
    parameter int IDX_W = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_reset_running,
    input  logic [IDX_W-1:0]   i_my_index,
    input  logic [IDX_W-1:0]   i_sel_index,
    input  logic               i_in_use,
    input  tts_pkg::t_cmd      i_cmd,
    input  logic [63:0]        i_now,
    input  logic [63:0]        i_wake_val,
    input  logic [31:0]        i_sp,
    // chain: search for first runnable, and carry of sp of a selected entry
    input  logic               i_found,
    input  logic [IDX_W-1:0]   i_found_idx,
    output logic               o_found,
    output logic [IDX_W-1:0]   o_found_idx,
    input  logic [31:0]        i_sp_chain,
    output logic [31:0]        o_sp_chain
);
    import tts_pkg::*;

    logic [1:0]  r_state;
    logic [63:0] r_wake;
    logic [31:0] r_sp;
    logic        sel;

    assign sel = (i_sel_index == i_my_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= i_reset_running ? ST_RUNNING : ST_TERMINATED;
            r_wake  <= '0;
            r_sp    <= '0;
        end else begin
            if (i_cmd.wake && i_in_use && r_state == ST_PAUSED && r_wake < i_now) begin
                r_state <= ST_RUNNABLE;
                r_wake  <= '0;
            end
            if (sel) begin
                if (i_cmd.set_sp)    r_sp <= i_sp;
                if (i_cmd.set_wake)  r_wake <= i_wake_val;
                if (i_cmd.set_state) r_state <= i_cmd.state_val;
                else if (i_cmd.demote && r_state == ST_RUNNING) r_state <= ST_RUNNABLE;
            end
        end
    end

    always_comb begin
        o_found     = i_found;
        o_found_idx = i_found_idx;
        if (!i_found && i_in_use && r_state == ST_RUNNABLE) begin
            o_found     = 1'b1;
            o_found_idx = i_my_index;
        end
        o_sp_chain = sel ? r_sp : i_sp_chain;
    end
endmodule

// ===== design/thread_table_scheduler_core.sv =====
// Top level of the thread table scheduler: handshake, sequencer, cell row.
//
// Usage: one request enters on the input channel (i_req_valid/o_req_ready,
// payload i_req); exactly one response leaves on the output channel
// (o_rsp_valid/i_rsp_ready, payload o_rsp).
// The table is a row of THREAD_COUNT cells. A request passes through
// capture, wake pass or table write, save sp / search, commit, readout.
// The row's search and readout chains are walked combinationally across
// the cells, so the cell count sets the path length, not the step count.
// A request is taken only once the last one is through: the next is
// accepted when the sequencer is idle and the response register is free
// or being taken in the same cycle.
// Reset (synchronous, active low): entry 0 running, others terminated,
// current entry 0, one entry in use, no response pending.
// While the receiver stalls, o_rsp is held stable; the block takes no
// request while its response register is full and not being taken.
module thread_table_scheduler_core #(
    parameter int THREAD_COUNT = tts_pkg::THREAD_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  tts_pkg::t_req  i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output tts_pkg::t_rsp  o_rsp
);
    import tts_pkg::*;

    localparam int IDX_W = $clog2(THREAD_COUNT);
    localparam int CNT_W = $clog2(THREAD_COUNT + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_WAKE   = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_COMMIT = 3'd3;
    localparam logic [2:0] S_READ   = 3'd4;

    logic [2:0]       r_fsm, n_fsm;
    t_req             r_req;
    logic [IDX_W-1:0] r_cur, n_cur;
    logic [CNT_W-1:0] r_used, n_used;
    logic             r_found;
    logic [IDX_W-1:0] r_found_idx;
    t_rsp             r_rsp, n_rsp;
    logic             r_rsp_valid, n_rsp_valid;

    t_cmd             cmd;
    logic [IDX_W-1:0] sel_idx;
    logic [63:0]      wake_sum;

    logic             fnd   [THREAD_COUNT+1];
    logic [IDX_W-1:0] fidx  [THREAD_COUNT+1];
    logic [31:0]      spch  [THREAD_COUNT+1];

    logic full;
    logic accept;

    assign full        = (r_used == CNT_W'(THREAD_COUNT));
    assign o_req_ready = (r_fsm == S_IDLE) && (!r_rsp_valid || i_rsp_ready);
    assign accept      = i_req_valid && o_req_ready;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;
    assign wake_sum    = r_req.now_time + r_req.sleep_duration;

    assign fnd[0]  = 1'b0;
    assign fidx[0] = '0;
    assign spch[0] = '0;

    genvar g;
    generate
        for (g = 0; g < THREAD_COUNT; g++) begin : g_cell
            tts_cell #(.IDX_W(IDX_W)) u_cell (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_reset_running(g == 0),
                .i_my_index     (IDX_W'(g)),
                .i_sel_index    (sel_idx),
                .i_in_use       (CNT_W'(g) < r_used),
                .i_cmd          (cmd),
                .i_now          (r_req.now_time),
                .i_wake_val     (wake_sum),
                .i_sp           (r_req.stack_pointer),
                .i_found        (fnd[g]),
                .i_found_idx    (fidx[g]),
                .o_found        (fnd[g+1]),
                .o_found_idx    (fidx[g+1]),
                .i_sp_chain     (spch[g]),
                .o_sp_chain     (spch[g+1])
            );
        end
    endgenerate

    // Sequencer: drives one broadcast command per cycle.
    always_comb begin
        cmd         = '0;
        sel_idx     = r_cur;
        n_fsm       = r_fsm;
        n_cur       = r_cur;
        n_used      = r_used;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        case (r_fsm)
            S_IDLE: begin
                if (accept) n_fsm = S_WAKE;
            end
            S_WAKE: begin
                n_fsm = S_SEARCH;
                case (r_req.operation)
                    OP_SCHEDULE: begin
                        cmd.wake = 1'b1;
                    end
                    OP_SLEEP: begin
                        cmd.set_wake  = 1'b1;
                        cmd.set_state = 1'b1;
                        cmd.state_val = ST_PAUSED;
                    end
                    OP_KILL: begin
                        cmd.set_state = 1'b1;
                        cmd.state_val = ST_TERMINATED;
                    end
                    default: begin
                        if (!full) begin
                            sel_idx       = r_used[IDX_W-1:0];
                            cmd.set_sp    = 1'b1;
                            cmd.set_state = 1'b1;
                            cmd.state_val = ST_RUNNABLE;
                        end
                    end
                endcase
            end
            S_SEARCH: begin
                // save caller sp; the search result is registered below
                n_fsm = S_COMMIT;
                if (r_req.operation == OP_SCHEDULE) cmd.set_sp = 1'b1;
            end
            S_COMMIT: begin
                n_fsm = S_READ;
                if (r_req.operation == OP_SCHEDULE && r_found) begin
                    cmd.demote = 1'b1;
                    sel_idx    = r_cur;
                end
            end
            S_READ: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    n_fsm = S_IDLE;
                    n_rsp_valid = 1'b1;
                    n_rsp = '0;
                    if (r_req.operation == OP_SCHEDULE) begin
                        if (r_found) begin
                            sel_idx       = r_found_idx;
                            cmd.set_state = 1'b1;
                            cmd.state_val = ST_RUNNING;
                            n_cur         = r_found_idx;
                        end
                        n_rsp.next_stack_pointer = spch[THREAD_COUNT];
                    end else if (r_req.operation == OP_CREATE) begin
                        if (full) n_rsp.status = 1'b1;
                        else begin
                            n_rsp.new_index = 4'(r_used);
                            n_used = r_used + 1'b1;
                        end
                    end
                    n_rsp.running_index = 4'(n_cur);
                end
            end
            default: n_fsm = S_IDLE;
        endcase
    end

    // search uses the found chain, readout the sp chain; sel_idx in READ points at found, else at current
    always_ff @(posedge i_clk) begin
        if (accept) r_req <= i_req;
        if (r_fsm == S_SEARCH) begin
            r_found     <= fnd[THREAD_COUNT];
            r_found_idx <= fidx[THREAD_COUNT];
        end
        r_rsp <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= S_IDLE;
            r_cur       <= '0;
            r_used      <= CNT_W'(1);
            r_rsp_valid <= 1'b0;
        end else begin
            r_fsm       <= n_fsm;
            r_cur       <= n_cur;
            r_used      <= n_used;
            r_rsp_valid <= n_rsp_valid;
        end
    end
endmodule

// ===== sim/thread_table_scheduler_core_checker.sv =====
// Checker: watches both channels, predicts each response and compares it.
module thread_table_scheduler_core_checker #(
    parameter int THREAD_COUNT = tts_pkg::THREAD_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    input  logic           i_req_ready,
    input  tts_pkg::t_req  i_req,
    input  logic           i_rsp_valid,
    input  logic           i_rsp_ready,
    input  tts_pkg::t_rsp  i_rsp,
    output int             o_fail_count,
    output int             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import tts_pkg::*;

    logic [1:0]  tbl_state [THREAD_COUNT];
    logic [63:0] tbl_wake  [THREAD_COUNT];
    logic [31:0] tbl_sp    [THREAD_COUNT];
    int          cur_slot;
    int          used_slots;
    t_rsp        rsp_queue [$];

    assign o_pending = rsp_queue.size();

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    task automatic table_reset();
        for (int i = 0; i < THREAD_COUNT; i++) begin
            tbl_state[i] = ST_TERMINATED;
            tbl_wake[i]  = '0;
            tbl_sp[i]    = '0;
        end
        tbl_state[0] = ST_RUNNING;
        cur_slot     = 0;
        used_slots   = 1;
    endtask

    // Applies one request to the shadow table and returns the response.
    function automatic t_rsp apply_request(input t_req rq);
        t_rsp r;
        int   c;
        c = cur_slot;
        r = '0;
        case (rq.operation)
            OP_SCHEDULE: begin
                for (int i = 0; i < used_slots; i++)
                    if (tbl_state[i] == ST_PAUSED && tbl_wake[i] < rq.now_time) begin
                        tbl_wake[i]  = '0;
                        tbl_state[i] = ST_RUNNABLE;
                    end
                tbl_sp[c] = rq.stack_pointer;
                for (int i = 0; i < used_slots; i++)
                    if (tbl_state[i] == ST_RUNNABLE) begin
                        if (tbl_state[c] == ST_RUNNING) tbl_state[c] = ST_RUNNABLE;
                        c = i;
                        tbl_state[i] = ST_RUNNING;
                        break;
                    end
                cur_slot = c;
                r.next_stack_pointer = tbl_sp[c];
            end
            OP_SLEEP: begin
                tbl_wake[c]  = rq.now_time + rq.sleep_duration;
                tbl_state[c] = ST_PAUSED;
            end
            OP_KILL: tbl_state[c] = ST_TERMINATED;
            default: begin
                if (used_slots >= THREAD_COUNT) begin
                    r.status = 1'b1;
                end else begin
                    r.new_index = 4'(used_slots);
                    tbl_sp[used_slots]    = rq.stack_pointer;
                    tbl_state[used_slots] = ST_RUNNABLE;
                    used_slots++;
                end
            end
        endcase
        r.running_index = 4'(c);
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        table_reset();
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (!i_rst_n) begin
            table_reset();
            rsp_queue.delete();
        end else begin
            if (i_rsp_valid && i_rsp_ready) begin
                if (rsp_queue.size() == 0) begin
                    report_mismatch("unexpected response", 64'(i_rsp), '0);
                end else begin
                    want = rsp_queue.pop_front();
                    if (i_rsp.running_index !== want.running_index)
                        report_mismatch("running_index", 64'(i_rsp.running_index),
                                        64'(want.running_index));
                    if (i_rsp.next_stack_pointer !== want.next_stack_pointer)
                        report_mismatch("next_stack_pointer",
                                        64'(i_rsp.next_stack_pointer),
                                        64'(want.next_stack_pointer));
                    if (i_rsp.status !== want.status)
                        report_mismatch("status", 64'(i_rsp.status), 64'(want.status));
                    if (i_rsp.new_index !== want.new_index)
                        report_mismatch("new_index", 64'(i_rsp.new_index),
                                        64'(want.new_index));
                end
            end
            if (i_req_valid && i_req_ready)
                rsp_queue.push_back(apply_request(i_req));
        end
    end
endmodule

// ===== sim/thread_table_scheduler_core_tb.sv =====
// Testbench top: clock, reset, request stimulus and final verdict.
module thread_table_scheduler_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tts_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic req_valid;
    logic req_ready;
    t_req req;
    logic rsp_valid;
    logic rsp_ready;
    t_rsp rsp;
    int   fail_count;
    int   pending;
    int   send_idle_pct;   // chance (percent) of a gap before a request
    int   recv_idle_pct;   // chance (percent) of stalling the response side

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    thread_table_scheduler_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp)
    );

    thread_table_scheduler_core_checker CHK (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req        (req),
        .i_rsp_valid  (rsp_valid),
        .i_rsp_ready  (rsp_ready),
        .i_rsp        (rsp),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver side: random stall, redrawn each falling edge.
    always @(negedge i_clk) begin
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Drives one request, holding it until accepted. Valid stays high
    // after acceptance; the next call either replaces the payload or drops
    // valid for a gap, so valid gets one assignment per falling edge.
    task automatic send_request(input t_req rq);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge i_clk);
        end
        req       <= rq;
        req_valid <= 1'b1;
        @(posedge i_clk);
        while (!req_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Random 64-bit time; often small values so wakeups actually happen.
    function automatic logic [63:0] pick_time();
        case ($urandom_range(3))
            0: return {$urandom, $urandom};
            1: return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(40));
            default: return 64'($urandom_range(200));
        endcase
    endfunction

    function automatic t_req random_request();
        t_req rq;
        int   pick;
        pick = $urandom_range(99);
        // Schedule dominates so the table keeps rotating through entries.
        if (pick < 50)      rq.operation = OP_SCHEDULE;
        else if (pick < 70) rq.operation = OP_SLEEP;
        else if (pick < 80) rq.operation = OP_KILL;
        else                rq.operation = OP_CREATE;
        rq.now_time       = pick_time();
        rq.sleep_duration = ($urandom_range(3) == 0) ? {$urandom, $urandom}
                                                     : 64'($urandom_range(100));
        rq.stack_pointer  = $urandom;
        return rq;
    endfunction

    function automatic t_req make_req(input logic [1:0] op, input logic [63:0] now_v,
                                      input logic [63:0] dur_v, input logic [31:0] sp_v);
        t_req rq;
        rq.operation      = op;
        rq.now_time       = now_v;
        rq.sleep_duration = dur_v;
        rq.stack_pointer  = sp_v;
        return rq;
    endfunction

    initial begin
        int wait_cycles;
        i_rst_n       = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        send_idle_pct = 13;
        recv_idle_pct = 60;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: nothing runnable, creates, sleep wrap, equal wakeup,
        // kill then switch away, full table refusal.
        send_request(make_req(OP_SCHEDULE, 64'd0, 64'd0, 32'hFFFF_FFFF));
        send_request(make_req(OP_CREATE, 64'd0, 64'd0, 32'h1111_0001));
        send_request(make_req(OP_CREATE, 64'd0, 64'd0, 32'hFFFF_FFFF));
        send_request(make_req(OP_SLEEP, 64'd100, 64'd50, 32'd0));
        send_request(make_req(OP_SCHEDULE, 64'd150, 64'd0, 32'hA5A5_0000));
        send_request(make_req(OP_SCHEDULE, 64'd151, 64'd0, 32'h5A5A_FFFF));
        send_request(make_req(OP_KILL, 64'd0, 64'd0, 32'd0));
        send_request(make_req(OP_SCHEDULE, 64'd0, 64'd0, 32'd0));
        send_request(make_req(OP_SLEEP, 64'hFFFF_FFFF_FFFF_FFF0,
                              64'hFFFF_FFFF_FFFF_FFFF, 32'd0));
        send_request(make_req(OP_SCHEDULE, 64'hFFFF_FFFF_FFFF_FFFF,
                              64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0001));
        for (int i = 0; i < 15; i++)
            send_request(make_req(OP_CREATE, 64'd0, 64'd0, $urandom));

        // Random: three idling phases of equal length.
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin
                send_idle_pct = 60;
                recv_idle_pct = 13;
            end else if (ph == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < 410; n++)
                send_request(random_request());
        end
        req_valid <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 100000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (20) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
